// ===== sv/ssf_pkg.sv =====
// Shared types, Q3.20 constants and the rounding multiply for the stereo clip softener.
// No dependencies; every other file except ssf_check imports this package.
package ssf_pkg;

    localparam int DEF_DELAY_DEPTH  = 16;
    localparam int DEF_SAMPLE_WIDTH = 24;

    localparam int CALC_W    = 24;      // working width, holds +-4.0 and every blend
    localparam int COEF_W    = 21;      // unsigned Q0.20 coefficient plus sign bit
    localparam int FRAC      = 20;
    localparam int PROD_W    = CALC_W + COEF_W;
    localparam int SPACING_W = 5;
    localparam int MAX_SPACING = 16;

    typedef logic signed [CALC_W-1:0] calc_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam longint LIMIT_Q = 64'sd4194304;

    localparam calc_t CLIP_Q      = 24'sd1001382;
    localparam calc_t NEG_CLIP_Q  = -24'sd1001382;
    localparam calc_t HARD_CLIP_Q = 24'sd740107;
    localparam calc_t SOFT_CLIP_Q = 24'sd261275;
    localparam coef_t SOFT_Q      = 21'sd273589;
    localparam coef_t HARD_Q      = 21'sd774987;

    localparam prod_t PROD_RND = prod_t'(1) <<< (FRAC - 1);

    localparam logic [SPACING_W-1:0] SPACING_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEEP_POS,
        ST_CLIP_POS,
        ST_KEEP_NEG,
        ST_CLIP_NEG
    } ssf_state_t;

    typedef struct packed {
        ssf_state_t phase;
        logic       load;
        logic       advance;
    } ssf_ctrl_t;

    // Product rounded half up, then floor shift by FRAC.
    function automatic calc_t mul_q(input calc_t a, input coef_t c);
        prod_t p;
        p = a * c + PROD_RND;
        return p[FRAC+CALC_W-1:FRAC];
    endfunction

endpackage

// ===== sv/stereo_clip_softener.sv =====
// Top level of the stereo clip softener: stream handshake, sequencer, spacing register.
// Depends on ssf_pkg and ssf_chan (which uses ssf_cell).
//
// Usage:
//   s_* carries one stereo frame per beat, m_* one delayed softened frame per beat;
//   tdata packs left in the low SAMPLE_WIDTH bits and right above it.
//   cfg_wen/cfg_wdata write the spacing register (delay stages, 1 to 16); write it
//   only while the block is idle.
//   Each accepted frame runs four phases on one constant multiplier per channel
//   (positive kept update, positive clip, negative kept update, negative clip)
//   after the accept cycle; no new frame is accepted until the last phase ends.
//   The result is registered at the end of the last phase, where m_tvalid is set.
//   The delay line is a row of cells per channel that advances once per frame;
//   the output is the value leaving stage 0 after the kept updates, so with spacing 1
//   each result is built from the previous frame's processed sample.
//   Reset clears the delay cells, clip flags and output valid, and sets spacing to 1.
//   When the receiver stalls, the finished beat holds on m_tdata, the next frame is
//   still accepted and processed, and it waits in its last phase until the output
//   register frees.
module stereo_clip_softener #(
    parameter int DELAY_DEPTH  = ssf_pkg::DEF_DELAY_DEPTH,
    parameter int SAMPLE_WIDTH = ssf_pkg::DEF_SAMPLE_WIDTH,
    localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ssf_pkg::SPACING_W-1:0]   cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [DATA_W-1:0]               s_tdata,   // left_sample, right_sample, zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [DATA_W-1:0]               m_tdata    // left_out, right_out, zero pad
);
    import ssf_pkg::*;

    localparam int IDXW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int LIM  = (MAX_SPACING < DELAY_DEPTH) ? MAX_SPACING : DELAY_DEPTH;

    ssf_state_t state_reg, state_next;
    logic [SPACING_W-1:0] spacing_reg, spacing_next;
    logic m_valid_reg, m_valid_next;
    logic [IDXW-1:0] last_idx;
    ssf_ctrl_t ctrl;
    logic signed [SAMPLE_WIDTH-1:0] left_out, right_out;

    always_comb
    begin
        if (spacing_reg == '0)
            last_idx = '0;
        else if (spacing_reg > SPACING_W'(LIM))
            last_idx = IDXW'(LIM - 1);
        else
            last_idx = IDXW'(spacing_reg - 1'b1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_KEEP_POS;
            end
            ST_KEEP_POS: state_next = ST_CLIP_POS;
            ST_CLIP_POS: state_next = ST_KEEP_NEG;
            ST_KEEP_NEG: state_next = ST_CLIP_NEG;
            ST_CLIP_NEG:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctrl.phase   = state_reg;
        ctrl.load    = 1'b0;
        ctrl.advance = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_CLIP_NEG:
            begin
                ctrl.advance = !m_valid_reg || m_tready;
            end
            ST_KEEP_POS, ST_CLIP_POS, ST_KEEP_NEG:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctrl.advance)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        spacing_next = cfg_wen ? cfg_wdata : spacing_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            spacing_reg <= SPACING_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            spacing_reg <= spacing_next;
        end
    end

    ssf_chan #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDXW         (IDXW)
    ) u_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .last_idx   (last_idx),
        .sample_in  (s_tdata[SAMPLE_WIDTH-1:0]),
        .sample_out (left_out)
    );

    ssf_chan #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDXW         (IDXW)
    ) u_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .last_idx   (last_idx),
        .sample_in  (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .sample_out (right_out)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({right_out, left_out});

endmodule

// ===== sv/ssf_cell.sv =====
// One stage of a channel's delay line: shifts from its upper neighbor or takes the new sample.
// Depends on ssf_pkg.
module ssf_cell #(
    parameter int IDX  = 0,
    parameter int IDXW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [IDXW-1:0]   last_idx,
    input  ssf_pkg::calc_t    from_next,
    input  ssf_pkg::calc_t    new_val,
    output ssf_pkg::calc_t    q
);
    import ssf_pkg::*;

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    calc_t q_reg;
    calc_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (advance)
        begin
            if (MY_IDX < last_idx)
                q_next = from_next;
            else if (MY_IDX == last_idx)
                q_next = new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== sv/ssf_chan.sv =====
// One channel: clamp, four-step soft clip recovery on a shared multiplier, delay row of cells.
// Depends on ssf_pkg and ssf_cell.
module ssf_chan #(
    parameter int DELAY_DEPTH  = ssf_pkg::DEF_DELAY_DEPTH,
    parameter int SAMPLE_WIDTH = ssf_pkg::DEF_SAMPLE_WIDTH,
    parameter int IDXW         = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssf_pkg::ssf_ctrl_t             ctrl,
    input  logic [IDXW-1:0]                last_idx,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
    import ssf_pkg::*;

    localparam int EW = (SAMPLE_WIDTH > CALC_W) ? SAMPLE_WIDTH : CALC_W;
    localparam longint SMAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint HI_L = (SMAX < LIMIT_Q) ? SMAX : LIMIT_Q;
    localparam longint LO_L = ((-SMAX - 1) > -LIMIT_Q) ? (-SMAX - 1) : -LIMIT_Q;
    localparam logic signed [EW-1:0] HI_E = EW'(HI_L);
    localparam logic signed [EW-1:0] LO_E = EW'(LO_L);
    localparam calc_t HI_C = calc_t'(HI_L);
    localparam calc_t LO_C = calc_t'(LO_L);

    function automatic calc_t sat_c(input calc_t v);
        if (v > HI_C)
            return HI_C;
        if (v < LO_C)
            return LO_C;
        return v;
    endfunction

    calc_t x_reg, x_next;
    calc_t kept_reg, kept_next;
    logic  was_pos_reg, was_pos_next;
    logic  was_neg_reg, was_neg_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg, out_next;

    logic signed [EW-1:0] in_ext;
    calc_t in_sat;
    calc_t mul_a, add_c, mul_r, new_val, kept_sat;
    coef_t mul_c;
    logic  x_lt_kept, x_gt_kept, clip_pos, clip_neg;
    logic signed [EW-1:0] kept_ext;

    calc_t stage_q  [DELAY_DEPTH];
    calc_t neighbor [DELAY_DEPTH];

    // Clamp the input to the smaller of +-4.0 and the sample range
    always_comb
    begin
        in_ext = EW'(sample_in);
        if (in_ext > HI_E)
            in_sat = HI_C;
        else if (in_ext < LO_E)
            in_sat = LO_C;
        else
            in_sat = in_ext[CALC_W-1:0];
    end

    assign x_lt_kept = x_reg < kept_reg;
    assign x_gt_kept = x_reg > kept_reg;
    assign clip_pos  = x_reg > CLIP_Q;
    assign clip_neg  = x_reg < NEG_CLIP_Q;

    // Operand selection for the one multiplier, one product per phase
    always_comb
    begin
        mul_a = kept_reg;
        mul_c = SOFT_Q;
        add_c = HARD_CLIP_Q;
        unique case (ctrl.phase)
            ST_KEEP_POS:
            begin
                mul_a = x_lt_kept ? x_reg : kept_reg;
                mul_c = x_lt_kept ? SOFT_Q : HARD_Q;
                add_c = x_lt_kept ? HARD_CLIP_Q : SOFT_CLIP_Q;
            end
            ST_CLIP_POS:
            begin
                mul_a = kept_reg;
                mul_c = SOFT_Q;
                add_c = HARD_CLIP_Q;
            end
            ST_KEEP_NEG:
            begin
                mul_a = x_gt_kept ? x_reg : kept_reg;
                mul_c = x_gt_kept ? SOFT_Q : HARD_Q;
                add_c = x_gt_kept ? -HARD_CLIP_Q : -SOFT_CLIP_Q;
            end
            ST_CLIP_NEG:
            begin
                mul_a = kept_reg;
                mul_c = SOFT_Q;
                add_c = -HARD_CLIP_Q;
            end
            default:
            begin
                mul_a = kept_reg;
                mul_c = SOFT_Q;
                add_c = HARD_CLIP_Q;
            end
        endcase
    end

    assign mul_r    = add_c + mul_q(mul_a, mul_c);
    assign new_val  = sat_c(clip_neg ? mul_r : x_reg);
    assign kept_sat = sat_c(kept_reg);
    assign kept_ext = EW'(kept_sat);

    always_comb
    begin
        x_next       = x_reg;
        kept_next    = kept_reg;
        was_pos_next = was_pos_reg;
        was_neg_next = was_neg_reg;
        out_next     = out_reg;
        if (ctrl.load)
        begin
            x_next    = in_sat;
            kept_next = stage_q[0];
        end
        case (ctrl.phase)
            ST_KEEP_POS:
            begin
                if (was_pos_reg)
                    kept_next = mul_r;
            end
            ST_CLIP_POS:
            begin
                was_pos_next = clip_pos;
                if (clip_pos)
                    x_next = mul_r;
            end
            ST_KEEP_NEG:
            begin
                if (was_neg_reg)
                    kept_next = mul_r;
            end
            ST_CLIP_NEG:
            begin
                if (ctrl.advance)
                begin
                    was_neg_next = clip_neg;
                    out_next     = kept_ext[SAMPLE_WIDTH-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pos_reg <= 1'b0;
            was_neg_reg <= 1'b0;
        end
        else
        begin
            was_pos_reg <= was_pos_next;
            was_neg_reg <= was_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        kept_reg <= kept_next;
        out_reg  <= out_next;
    end

    genvar i;
    generate
        for (i = 0; i < DELAY_DEPTH; i++)
        begin : g_stage
            if (i == DELAY_DEPTH - 1)
            begin : g_top
                assign neighbor[i] = new_val;
            end
            else
            begin : g_mid
                assign neighbor[i] = stage_q[i+1];
            end

            ssf_cell #(
                .IDX  (i),
                .IDXW (IDXW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (ctrl.advance),
                .last_idx  (last_idx),
                .from_next (neighbor[i]),
                .new_val   (new_val),
                .q         (stage_q[i])
            );
        end
    endgenerate

    assign sample_out = out_reg;

endmodule

// ===== sv/ssf_check.sv =====
// Port-level checks for the stereo clip softener, bound to the top level.
// Depends on stereo_clip_softener (bind target).
module ssf_check #(
    parameter int DATA_W = 48
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // An accepted frame keeps the input closed for its four phases
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened before the frame finished its phases");

    // A new result only appears from the last phase, never from idle
    a_result_from_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a frame in progress");

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind stereo_clip_softener ssf_check #(.DATA_W(DATA_W)) u_ssf_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/stereo_clip_softener_tb.sv =====
// Self-checking testbench for stereo_clip_softener: random and directed stereo frames
// with a cycle-free predictor of clamping, clip softening and the spacing delay line.
// Depends on ssf_pkg and the stereo_clip_softener RTL.
module stereo_clip_softener_tb;
    import ssf_pkg::*;

    localparam int SW      = 24;
    localparam int DEPTH   = 16;
    localparam int TDATA_W = 48;

    localparam longint LIM_Q    = 4194304;
    localparam longint CLIP_LVL = 1001382;
    localparam longint HARD_LVL = 740107;
    localparam longint SOFT_CO  = 273589;
    localparam longint SOFT_LVL = 261275;
    localparam longint HARD_CO  = 774987;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t right;
        sample_t left;
    } frame_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [SPACING_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;     // left_sample, right_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // left_out, right_out

    frame_t frames_to_send[$];
    frame_t frames_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    // predictor state, per channel (0 left, 1 right)
    logic [SPACING_W-1:0] spacing_q = SPACING_RESET;
    longint kept[2];
    bit     clipped_hi[2];
    bit     clipped_lo[2];
    longint line_q[2][DEPTH];

    stereo_clip_softener u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint clamp_q(longint v);
        if (v > LIM_Q)
            return LIM_Q;
        if (v < -LIM_Q)
            return -LIM_Q;
        return v;
    endfunction

    // round half up, floor shift
    function automatic longint scale_q(longint a, longint c);
        return (a * c + (64'sd1 <<< 19)) >>> 20;
    endfunction

    function automatic longint soften_channel(int ch, longint x_in);
        longint x;
        longint res;
        int     n;
        x = clamp_q(x_in);
        if (clipped_hi[ch])
        begin
            if (x < kept[ch])
                kept[ch] = HARD_LVL + scale_q(x, SOFT_CO);
            else
                kept[ch] = SOFT_LVL + scale_q(kept[ch], HARD_CO);
        end
        clipped_hi[ch] = 1'b0;
        if (x > CLIP_LVL)
        begin
            clipped_hi[ch] = 1'b1;
            x = HARD_LVL + scale_q(kept[ch], SOFT_CO);
        end
        if (clipped_lo[ch])
        begin
            if (x > kept[ch])
                kept[ch] = -HARD_LVL + scale_q(x, SOFT_CO);
            else
                kept[ch] = -SOFT_LVL + scale_q(kept[ch], HARD_CO);
        end
        clipped_lo[ch] = 1'b0;
        if (x < -CLIP_LVL)
        begin
            clipped_lo[ch] = 1'b1;
            x = -HARD_LVL + scale_q(kept[ch], SOFT_CO);
        end
        res = clamp_q(kept[ch]);
        n = (spacing_q == 0) ? 1 : (spacing_q > DEPTH) ? DEPTH : int'(spacing_q);
        for (int i = 0; i < n - 1; i++)
            line_q[ch][i] = line_q[ch][i + 1];
        line_q[ch][n - 1] = clamp_q(x);
        kept[ch] = line_q[ch][0];
        return res;
    endfunction

    function automatic frame_t predict_frame(frame_t f);
        frame_t r;
        r.left  = sample_t'(soften_channel(0, longint'(f.left)));
        r.right = sample_t'(soften_channel(1, longint'(f.right)));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // driver: predict on every accepted beat, then present the next frame or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                frames_due.push_back(predict_frame(frame_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= frames_to_send.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        frame_t got;
        frame_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = frame_t'(m_tdata);
                if (frames_due.size() == 0)
                    report_mismatch("unexpected beat, left", got.left, 0);
                else
                begin
                    want = frames_due.pop_front();
                    if (got.left !== want.left)
                        report_mismatch("left_out", got.left, want.left);
                    if (got.right !== want.right)
                        report_mismatch("right_out", got.right, want.right);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic sample_t random_sample();
        int     pick;
        longint v;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // around the clip level, either sign
            v = $urandom_range(950000, 1300000);
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (pick < 60)
            v = longint'($urandom_range(0, 8388608)) - LIM_Q;
        else if (pick < 80)
            v = longint'(sample_t'($urandom));
        else if (pick < 90)
            v = longint'($urandom_range(0, 400000)) - 200000;
        else
        begin
            case ($urandom_range(0, 4))
                0: v = 8388607;
                1: v = -8388608;
                2: v = LIM_Q;
                3: v = -LIM_Q;
                default: v = LIM_Q + 1;
            endcase
        end
        return sample_t'(v);
    endfunction

    task automatic queue_frame(longint l, longint r);
        frame_t f;
        f.left  = sample_t'(l);
        f.right = sample_t'(r);
        frames_to_send.push_back(f);
    endtask

    // wait until every frame is sent and every result has come back, or the wait times out
    task automatic drain();
        int waited;
        waited = 0;
        while (frames_to_send.size() != 0 || s_tvalid)
            @(negedge clk);
        while (frames_due.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
    endtask

    task automatic write_spacing(int v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= SPACING_W'(v);
        spacing_q = SPACING_W'(v);
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(int sp, int s_pct, int r_pct, int count, bit hold_mid);
        write_spacing(sp);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            queue_frame(longint'(random_sample()), longint'(random_sample()));
            // hold the sender until the block has emptied, then resume
            if (hold_mid && i == count / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            kept[c] = 0;
            clipped_hi[c] = 1'b0;
            clipped_lo[c] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
                line_q[c][i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames at the reset spacing
        queue_frame(0, 0);
        queue_frame(8388607, -8388608);
        queue_frame(1001382, -1001382);
        queue_frame(1001383, -1001383);
        queue_frame(500000, -500000);
        queue_frame(LIM_Q, -LIM_Q);
        queue_frame(LIM_Q + 1, -LIM_Q - 1);
        queue_frame(LIM_Q, -LIM_Q);
        queue_frame(-8388608, 8388607);
        queue_frame(0, 0);
        queue_frame(-1, 1);
        queue_frame(1048576, -1048576);
        queue_frame(2000000, 3000000);
        queue_frame(3000000, 2000000);
        queue_frame(-2000000, -3000000);
        queue_frame(2000000, -2000000);
        queue_frame(-2000000, 2000000);
        queue_frame(2000000, -2000000);
        queue_frame(100, -100);
        queue_frame(longint'(sample_t'(24'h555555)), longint'(sample_t'(24'hAAAAAA)));
        queue_frame(longint'(sample_t'(24'hAAAAAA)), longint'(sample_t'(24'h555555)));
        queue_frame(1001383, 1001383);
        queue_frame(1001383, -1001383);
        drain();

        run_phase(16, 0, 0, 200, 1'b0);
        run_phase(31, 85, 0, 150, 1'b0);
        run_phase(0, 0, 85, 200, 1'b0);
        run_phase(1, 20, 20, 300, 1'b1);
        run_phase($urandom_range(1, 16), 0, 0, 200, 1'b0);
        run_phase($urandom_range(0, 31), 20, 20, 200, 1'b0);
        run_phase(5, 85, 0, 100, 1'b0);
        run_phase(16, 0, 85, 150, 1'b0);

        for (int i = 0; i < frames_due.size(); i++)
            report_mismatch("missing beat, left", 0, frames_due[i].left);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(12 * 600000);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ssf_pkg.sv
sv/ssf_cell.sv
sv/ssf_chan.sv
sv/stereo_clip_softener.sv
sv/ssf_check.sv
verif/stereo_clip_softener_tb.sv
